>>> src/rdsc_pkg.sv
// ----------------------------------------------------------------------------
// rdsc_pkg: shared definitions of the radix digit string converter
// Field widths, base limits, the command word passed from the front end to
// the back end, and the ASCII digit table.
// ----------------------------------------------------------------------------
package rdsc_pkg;

    localparam int VALUE_W        = 64;
    localparam int RADIX_W        = 5;
    localparam int CHAR_W         = 8;
    localparam int COUNT_W        = 7;
    localparam int DIGIT_W        = 4;
    localparam int VALUE_BITS_DEF = 64;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    // Lower-case ASCII for the digit values 0 to 15.
    localparam logic [CHAR_W-1:0] DIGIT_TABLE [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    // One classified conversion request.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] base;
        logic               zero;
    } cmd_t;

endpackage

>>> src/rdsc_if.sv
// ----------------------------------------------------------------------------
// rdsc_if: word channels of the radix digit string converter
// The request channel carries a value and a radix; the digit channel carries
// one ASCII digit with its run information.
// ----------------------------------------------------------------------------
interface rdsc_in_if
    import rdsc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);
endinterface

interface rdsc_out_if
    import rdsc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CHAR_W-1:0]  digit_char;
    logic [COUNT_W-1:0] digit_count;
    logic               last_digit;
    logic               empty_result;

    modport source (output valid, output digit_char, output digit_count,
                    output last_digit, output empty_result, input ready);
    modport sink   (input valid, input digit_char, input digit_count,
                    input last_digit, input empty_result, output ready);
endinterface

>>> src/rdsc_front.sv
// ----------------------------------------------------------------------------
// rdsc_front: request front end
// Masks the value, saturates the radix, flags a zero value and holds the
// classified commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rdsc_front
    import rdsc_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    rdsc_in_if.sink       item,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output cmd_t          cmd
);

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    cmd_t       incoming;
    logic       push;
    logic       pop;

    always_comb
    begin
        incoming.value = VALUE_W'(item.value[VALUE_BITS-1:0]);
        if (item.radix inside {[5'd0:5'd1]})
        begin
            incoming.base = RADIX_MIN;
        end
        else if (item.radix > RADIX_MAX)
        begin
            incoming.base = RADIX_MAX;
        end
        else
        begin
            incoming.base = item.radix;
        end
        incoming.zero = (incoming.value == '0);
    end

    assign item.ready = (fill_reg != 2'd2);
    assign cmd_valid  = (fill_reg != 2'd0);
    assign cmd        = q_reg[rd_ptr_reg];
    assign push       = item.valid && item.ready;
    assign pop        = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

>>> src/rdsc_back.sv
// ----------------------------------------------------------------------------
// rdsc_back: digit generation and emission
// Divides the value by the base eight bits per cycle, stores the remainders
// in a digit memory and replays them most significant first through an
// output register.
// ----------------------------------------------------------------------------
module rdsc_back
    import rdsc_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  cmd_t          cmd,
    rdsc_out_if.source    digit
);

    localparam int CHUNKS = (VALUE_BITS + 7) / 8;
    localparam int PAD_W  = CHUNKS * 8;
    localparam int CH_W   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int IDX_W  = $clog2(VALUE_BITS);
    localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHUNKS - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [PAD_W-1:0]   work_reg, work_next;
    logic [RADIX_W-1:0] base_reg, base_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;
    logic [CH_W-1:0]    ch_reg, ch_next;
    logic [CNT_W-1:0]   dcnt_reg, dcnt_next;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               rd_done_reg, rd_done_next;
    logic               pend_reg, pend_next;
    logic               pend_last_reg, pend_last_next;
    logic               out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               last_reg, last_next;
    logic               empty_reg, empty_next;

    logic [DIGIT_W-1:0] mem [VALUE_BITS];
    logic [DIGIT_W-1:0] mem_rd_reg;
    logic               mem_we;
    logic               rd_en;
    logic               out_free;
    logic               load_out;

    logic [7:0]         top_byte;
    logic [7:0]         qbyte;
    logic [4:0]         trial;
    logic [DIGIT_W-1:0] rem_div;
    logic [PAD_W-1:0]   work_shift;

    // Eight restoring division steps on the top byte of the dividend.
    always_comb
    begin
        top_byte = work_reg[PAD_W-1 -: 8];
        rem_div  = rem_reg;
        qbyte    = '0;
        trial    = '0;
        for (int i = 7; i >= 0; i--)
        begin
            trial = {rem_div, top_byte[i]};
            if (trial >= base_reg)
            begin
                qbyte[i] = 1'b1;
                rem_div  = DIGIT_W'(trial - base_reg);
            end
            else
            begin
                rem_div  = trial[DIGIT_W-1:0];
            end
        end
        work_shift = (work_reg << 8) | PAD_W'(qbyte);
    end

    assign out_free = !out_valid_reg || digit.ready;

    always_comb
    begin
        state_next     = state_reg;
        work_next      = work_reg;
        base_next      = base_reg;
        rem_next       = rem_reg;
        ch_next        = ch_reg;
        dcnt_next      = dcnt_reg;
        total_next     = total_reg;
        rd_idx_next    = rd_idx_reg;
        rd_done_next   = rd_done_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        empty_next     = empty_reg;
        cmd_ready      = 1'b0;
        mem_we         = 1'b0;
        rd_en          = 1'b0;
        load_out       = 1'b0;

        if (out_valid_reg && digit.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.zero)
                    begin
                        if (out_free)
                        begin
                            cmd_ready      = 1'b1;
                            out_valid_next = 1'b1;
                            char_next      = '0;
                            count_next     = '0;
                            last_next      = 1'b1;
                            empty_next     = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd_ready  = 1'b1;
                        work_next  = PAD_W'(cmd.value[VALUE_BITS-1:0]);
                        base_next  = cmd.base;
                        rem_next   = '0;
                        ch_next    = '0;
                        dcnt_next  = '0;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                rem_next  = rem_div;
                work_next = work_shift;
                ch_next   = ch_reg + CH_W'(1);
                if (ch_reg == CH_LAST)
                begin
                    mem_we    = 1'b1;
                    dcnt_next = dcnt_reg + CNT_W'(1);
                    rem_next  = '0;
                    ch_next   = '0;
                    if (work_shift == '0)
                    begin
                        state_next   = S_EMIT;
                        total_next   = dcnt_reg + CNT_W'(1);
                        rd_idx_next  = dcnt_reg[IDX_W-1:0];
                        rd_done_next = 1'b0;
                    end
                end
            end
            S_EMIT:
            begin
                load_out = pend_reg && out_free;
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    char_next      = DIGIT_TABLE[mem_rd_reg];
                    count_next     = COUNT_W'(total_reg);
                    last_next      = pend_last_reg;
                    empty_next     = 1'b0;
                    pend_next      = 1'b0;
                    if (pend_last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
                if (!rd_done_reg && (!pend_reg || load_out))
                begin
                    rd_en          = 1'b1;
                    pend_next      = 1'b1;
                    pend_last_next = (rd_idx_reg == '0);
                    if (rd_idx_reg == '0)
                    begin
                        rd_done_next = 1'b1;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg - IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_reg        <= '0;
            dcnt_reg      <= '0;
            rd_done_reg   <= 1'b1;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            dcnt_reg      <= dcnt_next;
            rd_done_reg   <= rd_done_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg   <= work_next;
        base_reg   <= base_next;
        rem_reg    <= rem_next;
        total_reg  <= total_next;
        rd_idx_reg <= rd_idx_next;
        char_reg   <= char_next;
        count_reg  <= count_next;
        last_reg   <= last_next;
        empty_reg  <= empty_next;
    end

    // Digit memory: one write port during division, one read port during
    // emission, read data registered.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[dcnt_reg[IDX_W-1:0]] <= rem_div;
        end
        if (rd_en)
        begin
            mem_rd_reg <= mem[rd_idx_reg];
        end
    end

    assign digit.valid        = out_valid_reg;
    assign digit.digit_char   = char_reg;
    assign digit.digit_count  = count_reg;
    assign digit.last_digit   = last_reg;
    assign digit.empty_result = empty_reg;

    a_dcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dcnt_reg <= CNT_W'(VALUE_BITS))
        else $error("digit count exceeds the value width");

    a_pend_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> state_reg == S_EMIT)
        else $error("digit read pending outside emission");

    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && empty_reg) |-> (count_reg == '0 && last_reg))
        else $error("empty word without zero count and last flag");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && load_out && pend_last_reg) |=> state_reg == S_IDLE)
        else $error("run did not end after its last digit");

endmodule

>>> src/radix_digit_string_converter.sv
// ----------------------------------------------------------------------------
// radix_digit_string_converter: unsigned value to ASCII digits in base 2..16
// Top level joining the request front end and the division and emission
// back end.
// ----------------------------------------------------------------------------
// Usage. A request word on the item channel carries a value and a radix. The
// low VALUE_BITS bits of the value are converted; a radix below two is taken
// as two and one above sixteen as sixteen. The digit channel then delivers
// one word per digit, most significant first, as lower-case ASCII. Every
// digit word carries the total digit count, and the final one has last_digit
// set. A zero value yields a single word with empty_result and last_digit set,
// a zero character and a count of zero.
// Timing. The front end takes each request into a two-entry queue. The back
// end is a shared restoring divider that handles eight dividend bits per
// cycle. Emission then reads the digit memory at one digit per cycle while
// the receiver holds ready high. Requests are converted one at a time; the
// queue absorbs up to two waiting requests.
// Stalls. When the receiver holds ready low, the output register keeps its
// word and emission pauses; the front end keeps accepting until its queue
// is full. Reset clears all control state and drops any run in progress.
// ----------------------------------------------------------------------------
module radix_digit_string_converter
    import rdsc_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rdsc_in_if.sink    item,
    rdsc_out_if.source digit
);

    // Classified requests travelling from the front end to the back end.
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    rdsc_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    rdsc_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .digit     (digit)
    );

endmodule

>>> dv/tb_radix_digit_string_converter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_radix_digit_string_converter: self-checking bench of the digit converter
// Sends conversion requests (directed corner values first, then random ones)
// and compares every digit word, field by field, with the digits the bench
// predicts on its own. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_radix_digit_string_converter;
    import rdsc_pkg::*;

    // One expected or observed word of the digit channel.
    typedef struct packed {
        logic [CHAR_W-1:0]  digit_char;
        logic [COUNT_W-1:0] digit_count;
        logic               last_digit;
        logic               empty_result;
    } digit_word_t;

    // The scoreboard turns every accepted request into the run of digit words
    // the block must produce, and checks the words that come out in order.
    class digit_run_scoreboard;
        digit_word_t pending_digits[$];
        int unsigned mismatches;
        int unsigned words_checked;

        // Work out the digits of one accepted request, most significant first.
        function void note_request(logic [VALUE_W-1:0] value,
                                   logic [RADIX_W-1:0] radix);
            logic [VALUE_W-1:0] rest;
            logic [VALUE_W-1:0] base;
            logic [DIGIT_W-1:0] digits [64];
            logic [CHAR_W-1:0]  d;
            int                 n;
            digit_word_t        w;
            rest = value & ({VALUE_W{1'b1}} >> (VALUE_W - VALUE_BITS_DEF));
            // Bases outside 2..16 saturate to the nearest limit.
            if (radix < RADIX_MIN)
                base = VALUE_W'(RADIX_MIN);
            else if (radix > RADIX_MAX)
                base = VALUE_W'(RADIX_MAX);
            else
                base = VALUE_W'(radix);
            // A zero value has no digits and yields a single empty word.
            if (rest == '0)
            begin
                w.digit_char   = '0;
                w.digit_count  = '0;
                w.last_digit   = 1'b1;
                w.empty_result = 1'b1;
                pending_digits.push_back(w);
                return;
            end
            n = 0;
            while (rest != '0)
            begin
                digits[n] = DIGIT_W'(rest % base);
                rest = rest / base;
                n++;
            end
            for (int k = n - 1; k >= 0; k--)
            begin
                d = CHAR_W'(digits[k]);
                w.digit_char   = (d < 8'd10) ? 8'h30 + d : 8'h61 + d - 8'd10;
                w.digit_count  = COUNT_W'(n);
                w.last_digit   = (k == 0);
                w.empty_result = 1'b0;
                pending_digits.push_back(w);
            end
        endfunction

        task report_mismatch(string what, longint unsigned got, longint unsigned want);
            mismatches++;
            if (mismatches <= 30)
                $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
        endtask

        task check_digit(digit_word_t got);
            digit_word_t want;
            words_checked++;
            if (pending_digits.size() == 0)
            begin
                report_mismatch("digit word with none expected", got, 0);
                return;
            end
            want = pending_digits.pop_front();
            if (got.digit_char !== want.digit_char)
                report_mismatch("digit_char", got.digit_char, want.digit_char);
            if (got.digit_count !== want.digit_count)
                report_mismatch("digit_count", got.digit_count, want.digit_count);
            if (got.last_digit !== want.last_digit)
                report_mismatch("last_digit", got.last_digit, want.last_digit);
            if (got.empty_result !== want.empty_result)
                report_mismatch("empty_result", got.empty_result, want.empty_result);
        endtask
    endclass

    // Corner requests: zero in two bases, the all-ones value in small and
    // large bases (the longest run is 64 binary digits), values with the top
    // bit set, saturated bases at both ends, and exact powers of the base.
    localparam int DIRECTED_N = 24;
    localparam logic [VALUE_W-1:0] DIRECTED_VALUE [DIRECTED_N] = '{
        64'd0,                  64'd0,                  64'd1,
        64'd1,                  64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
        64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 64'h8000_0000_0000_0000,
        64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, 64'd255,
        64'd255,                64'd255,                64'd255,
        64'hfedc_ba98_7654_3210, 64'd999999,             64'd1000000,
        64'hffff_ffff_ffff_fffe, 64'd1220703125,         64'hdead_beef_cafe_f00d,
        64'h0123_4567_89ab_cdef, 64'd143,                64'h5555_5555_5555_5555
    };
    localparam logic [RADIX_W-1:0] DIRECTED_RADIX [DIRECTED_N] = '{
        5'd10, 5'd0,  5'd2,  5'd16, 5'd2,  5'd16, 5'd10, 5'd3,
        5'd2,  5'd10, 5'd8,  5'd0,  5'd1,  5'd17, 5'd31, 5'd16,
        5'd10, 5'd10, 5'd4,  5'd5,  5'd6,  5'd7,  5'd12, 5'd13
    };
    localparam int RANDOM_N = 290;

    logic clk;
    logic rst_n;

    rdsc_in_if  item_ch ();
    rdsc_out_if digit_ch ();

    digit_run_scoreboard board = new();

    radix_digit_string_converter DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_ch),
        .digit (digit_ch)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Idle lengths shared by both sides: often none, mostly short, a few long.
    function automatic int unsigned idle_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return 0;
        else if (pick < 85)
            return $urandom_range(1, 3);
        else if (pick < 97)
            return $urandom_range(4, 20);
        else
            return $urandom_range(21, 60);
    endfunction

    // Offer one request word after a random gap and hold it until accepted.
    // The word is noted at the edge that accepts it, so the predicted digits
    // are always queued before the first digit word can appear.
    task automatic send_request(input logic [VALUE_W-1:0] value,
                                input logic [RADIX_W-1:0] radix);
        int unsigned gap;
        gap = idle_gap();
        if (gap != 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.value <= value;
        item_ch.radix <= radix;
        do
            @(posedge clk);
        while (!item_ch.ready);
        board.note_request(value, radix);
    endtask

    // Stop offering and let every predicted digit word drain out.
    task automatic wait_all_digits();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.pending_digits.size() != 0)
            @(posedge clk);
    endtask

    // Request side: reset, directed corners, then random requests.
    initial
    begin
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
        logic [VALUE_W-1:0] full;
        int unsigned        shape;
        rst_n         <= 1'b0;
        item_ch.valid <= 1'b0;
        item_ch.value <= '0;
        item_ch.radix <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_N; i++)
            send_request(DIRECTED_VALUE[i], DIRECTED_RADIX[i]);
        wait_all_digits();

        for (int i = 0; i < RANDOM_N; i++)
        begin
            // Halfway through, the sender pauses until the block is empty.
            if (i == RANDOM_N / 2)
                wait_all_digits();
            full  = {$urandom, $urandom};
            shape = $urandom_range(0, 9);
            // Mix full-width values with short ones, all-ones masks, powers of
            // two and the values one below them, and the occasional zero.
            case (shape)
                0: value = '0;
                1, 2, 3, 4: value = full;
                5, 6, 7: value = full >> $urandom_range(1, 63);
                8: value = {VALUE_W{1'b1}} >> $urandom_range(0, 63);
                default: value = (64'd1 << $urandom_range(0, 63)) - $urandom_range(0, 1);
            endcase
            // Mostly legal bases; now and then any 5-bit code, so that the
            // saturation at both ends keeps being exercised.
            if ($urandom_range(0, 6) == 0)
                radix = RADIX_W'($urandom_range(0, 31));
            else
                radix = RADIX_W'($urandom_range(2, 16));
            send_request(value, radix);
        end

        wait_all_digits();
        // A late extra word would still show up within the longest run time.
        repeat (600) @(posedge clk);
        if (board.mismatches == 0 && board.pending_digits.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Digit side: checks each accepted word and drives ready with random
    // stretches of stalling. Once, after enough words have passed, ready is
    // held low for a long stretch while the sender keeps offering requests,
    // so the request queue fills and the block has to stall its input.
    initial
    begin
        digit_word_t seen;
        logic        next_ready;
        int unsigned low_left;
        int unsigned high_left;
        int unsigned hold_left;
        bit          held;
        low_left  = 0;
        high_left = 0;
        hold_left = 0;
        held      = 1'b0;
        digit_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && digit_ch.valid && digit_ch.ready)
            begin
                seen.digit_char   = digit_ch.digit_char;
                seen.digit_count  = digit_ch.digit_count;
                seen.last_digit   = digit_ch.last_digit;
                seen.empty_result = digit_ch.empty_result;
                board.check_digit(seen);
            end
            if (!held && board.words_checked >= 500)
            begin
                held      = 1'b1;
                hold_left = 400;
            end
            if (!rst_n)
                next_ready = 1'b0;
            else if (hold_left != 0)
            begin
                next_ready = 1'b0;
                hold_left--;
            end
            else
            begin
                if (low_left == 0 && high_left == 0)
                begin
                    // Now and then a long stretch with ready held high.
                    high_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
                    low_left  = idle_gap();
                end
                if (low_left != 0)
                begin
                    next_ready = 1'b0;
                    low_left--;
                end
                else
                begin
                    next_ready = 1'b1;
                    high_left--;
                end
            end
            digit_ch.ready <= next_ready;
        end
    end

    // Watchdog: far beyond the slowest correct run, even with every request
    // giving 64 digits and every digit waiting out the longest stall.
    initial
    begin
        #100000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> sim.f
src/rdsc_pkg.sv
src/rdsc_if.sv
src/rdsc_front.sv
src/rdsc_back.sv
src/radix_digit_string_converter.sv
dv/tb_radix_digit_string_converter.sv
